FILE: rtl/operator_token_classifier_macros.svh
// Assertion macros for the operator token classifier.
// No dependencies; included by the top level before its assertions.
`ifndef OPERATOR_TOKEN_CLASSIFIER_MACROS_SVH
`define OPERATOR_TOKEN_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define OTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define OTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define OTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/otc_pkg.sv
// Shared types and constants for the operator token classifier.
// No dependencies; imported by otc_decode and the top level.
`timescale 1ns / 1ps
package otc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_kind;
    typedef logic [1:0] t_len;
    typedef logic [1:0] t_outcome;

    typedef struct packed {
        t_kind    kind;
        t_len     consumed;
        t_outcome outcome;
    } t_otc_result;

    // Character codes
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_STAR  = 8'h2A;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_PCT   = 8'h25;
    localparam t_byte CH_EQ    = 8'h3D;
    localparam t_byte CH_BANG  = 8'h21;
    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_PIPE  = 8'h7C;
    localparam t_byte CH_CARET = 8'h5E;
    localparam t_byte CH_TILDE = 8'h7E;
    localparam t_byte CH_LPAR  = 8'h28;
    localparam t_byte CH_RPAR  = 8'h29;
    localparam t_byte CH_LBRK  = 8'h5B;
    localparam t_byte CH_RBRK  = 8'h5D;
    localparam t_byte CH_LBRC  = 8'h7B;
    localparam t_byte CH_RBRC  = 8'h7D;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_QUEST = 8'h3F;
    localparam t_byte CH_DOT   = 8'h2E;
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;

    // Token kinds, dense in match order
    localparam t_kind K_INC      = 6'd0;
    localparam t_kind K_ADD_EQ   = 6'd1;
    localparam t_kind K_ADD      = 6'd2;
    localparam t_kind K_DEC      = 6'd3;
    localparam t_kind K_SUB_EQ   = 6'd4;
    localparam t_kind K_ARROW    = 6'd5;
    localparam t_kind K_SUB      = 6'd6;
    localparam t_kind K_MUL_EQ   = 6'd7;
    localparam t_kind K_MUL      = 6'd8;
    localparam t_kind K_DIV_EQ   = 6'd9;
    localparam t_kind K_DIV      = 6'd10;
    localparam t_kind K_MOD      = 6'd11;
    localparam t_kind K_EQ_EQ    = 6'd12;
    localparam t_kind K_ASSIGN   = 6'd13;
    localparam t_kind K_NE       = 6'd14;
    localparam t_kind K_NOT      = 6'd15;
    localparam t_kind K_SHL3     = 6'd16;
    localparam t_kind K_LE       = 6'd17;
    localparam t_kind K_SHL      = 6'd18;
    localparam t_kind K_LT       = 6'd19;
    localparam t_kind K_SHR3     = 6'd20;
    localparam t_kind K_GE       = 6'd21;
    localparam t_kind K_SHR      = 6'd22;
    localparam t_kind K_GT       = 6'd23;
    localparam t_kind K_LAND     = 6'd24;
    localparam t_kind K_BAND     = 6'd25;
    localparam t_kind K_LOR      = 6'd26;
    localparam t_kind K_BOR      = 6'd27;
    localparam t_kind K_XOR      = 6'd28;
    localparam t_kind K_BNOT     = 6'd29;
    localparam t_kind K_LPAR     = 6'd30;
    localparam t_kind K_RPAR     = 6'd31;
    localparam t_kind K_LBRK     = 6'd32;
    localparam t_kind K_RBRK     = 6'd33;
    localparam t_kind K_LBRC     = 6'd34;
    localparam t_kind K_RBRC     = 6'd35;
    localparam t_kind K_SEMI     = 6'd36;
    localparam t_kind K_COMMA    = 6'd37;
    localparam t_kind K_COLON    = 6'd38;
    localparam t_kind K_QUEST    = 6'd39;
    localparam t_kind K_DOT      = 6'd40;
    localparam t_kind K_ERROR    = 6'd41;
    localparam t_kind K_NONE     = 6'd0;

    // Consumed byte counts
    localparam t_len LEN_0 = 2'd0;
    localparam t_len LEN_1 = 2'd1;
    localparam t_len LEN_2 = 2'd2;
    localparam t_len LEN_3 = 2'd3;

    // Outcome codes
    localparam t_outcome OUT_TOKEN    = 2'd0;
    localparam t_outcome OUT_NUMBER   = 2'd1;
    localparam t_outcome OUT_SKIPLINE = 2'd2;

endpackage

FILE: rtl/otc_decode.sv
// Combinational maximal-munch operator decode over a three-byte window.
// Depends on otc_pkg.
`timescale 1ns / 1ps
module otc_decode (
    input  otc_pkg::t_byte       i_cur,
    input  otc_pkg::t_byte       i_next,
    input  otc_pkg::t_byte       i_after,
    output otc_pkg::t_otc_result o_result
);
    import otc_pkg::*;

    logic next_eq;
    logic next_is_digit;

    assign next_eq       = (i_next == CH_EQ);
    assign next_is_digit = (i_next >= CH_ZERO) && (i_next <= CH_NINE);

    always_comb begin
        o_result = '{kind: K_ERROR, consumed: LEN_1, outcome: OUT_TOKEN};
        unique case (i_cur)
            CH_PLUS: begin
                if (i_next == CH_PLUS)  o_result = '{K_INC, LEN_2, OUT_TOKEN};
                else if (next_eq)       o_result = '{K_ADD_EQ, LEN_2, OUT_TOKEN};
                else                    o_result = '{K_ADD, LEN_1, OUT_TOKEN};
            end
            CH_MINUS: begin
                if (i_next == CH_MINUS)   o_result = '{K_DEC, LEN_2, OUT_TOKEN};
                else if (next_eq)         o_result = '{K_SUB_EQ, LEN_2, OUT_TOKEN};
                else if (i_next == CH_GT) o_result = '{K_ARROW, LEN_2, OUT_TOKEN};
                else                      o_result = '{K_SUB, LEN_1, OUT_TOKEN};
            end
            CH_STAR: begin
                if (next_eq) o_result = '{K_MUL_EQ, LEN_2, OUT_TOKEN};
                else         o_result = '{K_MUL, LEN_1, OUT_TOKEN};
            end
            CH_SLASH: begin
                if (next_eq) o_result = '{K_DIV_EQ, LEN_2, OUT_TOKEN};
                else         o_result = '{K_DIV, LEN_1, OUT_TOKEN};
            end
            CH_PCT: o_result = '{K_MOD, LEN_1, OUT_TOKEN};
            CH_EQ: begin
                if (next_eq) o_result = '{K_EQ_EQ, LEN_2, OUT_TOKEN};
                else         o_result = '{K_ASSIGN, LEN_1, OUT_TOKEN};
            end
            CH_BANG: begin
                if (next_eq) o_result = '{K_NE, LEN_2, OUT_TOKEN};
                else         o_result = '{K_NOT, LEN_1, OUT_TOKEN};
            end
            CH_LT: begin
                // three-byte shift wins over <=, and <<= stays <<
                if (i_next == CH_LT && i_after == CH_LT)
                    o_result = '{K_SHL3, LEN_3, OUT_TOKEN};
                else if (next_eq)         o_result = '{K_LE, LEN_2, OUT_TOKEN};
                else if (i_next == CH_LT) o_result = '{K_SHL, LEN_2, OUT_TOKEN};
                else                      o_result = '{K_LT, LEN_1, OUT_TOKEN};
            end
            CH_GT: begin
                if (i_next == CH_GT && i_after == CH_GT)
                    o_result = '{K_SHR3, LEN_3, OUT_TOKEN};
                else if (next_eq)         o_result = '{K_GE, LEN_2, OUT_TOKEN};
                else if (i_next == CH_GT) o_result = '{K_SHR, LEN_2, OUT_TOKEN};
                else                      o_result = '{K_GT, LEN_1, OUT_TOKEN};
            end
            CH_AMP: begin
                if (i_next == CH_AMP) o_result = '{K_LAND, LEN_2, OUT_TOKEN};
                else                  o_result = '{K_BAND, LEN_1, OUT_TOKEN};
            end
            CH_PIPE: begin
                if (i_next == CH_PIPE) o_result = '{K_LOR, LEN_2, OUT_TOKEN};
                else                   o_result = '{K_BOR, LEN_1, OUT_TOKEN};
            end
            CH_CARET: o_result = '{K_XOR, LEN_1, OUT_TOKEN};
            CH_TILDE: o_result = '{K_BNOT, LEN_1, OUT_TOKEN};
            CH_LPAR:  o_result = '{K_LPAR, LEN_1, OUT_TOKEN};
            CH_RPAR:  o_result = '{K_RPAR, LEN_1, OUT_TOKEN};
            CH_LBRK:  o_result = '{K_LBRK, LEN_1, OUT_TOKEN};
            CH_RBRK:  o_result = '{K_RBRK, LEN_1, OUT_TOKEN};
            CH_LBRC:  o_result = '{K_LBRC, LEN_1, OUT_TOKEN};
            CH_RBRC:  o_result = '{K_RBRC, LEN_1, OUT_TOKEN};
            CH_SEMI:  o_result = '{K_SEMI, LEN_1, OUT_TOKEN};
            CH_COMMA: o_result = '{K_COMMA, LEN_1, OUT_TOKEN};
            CH_COLON: o_result = '{K_COLON, LEN_1, OUT_TOKEN};
            CH_QUEST: o_result = '{K_QUEST, LEN_1, OUT_TOKEN};
            CH_DOT: begin
                // dot before a digit opens a number; consume nothing
                if (next_is_digit) o_result = '{K_NONE, LEN_0, OUT_NUMBER};
                else               o_result = '{K_DOT, LEN_1, OUT_TOKEN};
            end
            CH_HASH: o_result = '{K_NONE, LEN_1, OUT_SKIPLINE};
            default: o_result = '{K_ERROR, LEN_1, OUT_TOKEN};
        endcase
    end

endmodule

FILE: rtl/operator_token_classifier.sv
// Operator token classifier: top level with input and result registers.
// Depends on otc_pkg, otc_decode and operator_token_classifier_macros.svh.
//
// Usage:
//   Drive i_cur_byte, i_next_byte and i_after_byte (the lexer byte and its two
//   lookahead bytes, 0 at end of text) and raise start. A beat is taken at
//   every rising edge where start is high and busy is low; busy never rises,
//   so a new window can be offered every cycle.
//   Once the beat has passed the input and result registers, o_strobe is high
//   for exactly one cycle with o_token_kind, o_consumed and o_outcome. The decode
//   sits between the two registers; throughput is one window per cycle, limited
//   only by the single decode stage.
//   o_outcome: token emitted, number starts here (nothing consumed), or skip
//   to end of line ('#' consumed). Unknown bytes give the error kind.
//   The receiver cannot stall: every strobed result must be taken in its
//   cycle, and nothing is buffered beyond the two registers.
//   Reset (i_rst_n low, synchronous) drops any beat in flight and clears the
//   strobe; payload registers keep whatever they held.
`timescale 1ns / 1ps
`include "operator_token_classifier_macros.svh"
module operator_token_classifier (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  otc_pkg::t_byte    i_cur_byte,
    input  otc_pkg::t_byte    i_next_byte,
    input  otc_pkg::t_byte    i_after_byte,
    output logic              o_strobe,
    output otc_pkg::t_kind    o_token_kind,
    output otc_pkg::t_len     o_consumed,
    output otc_pkg::t_outcome o_outcome
);
    import otc_pkg::*;

    logic        r_in_vld;
    logic        n_in_vld;
    t_byte       r_cur;
    t_byte       r_next;
    t_byte       r_after;
    logic        r_out_vld;
    t_otc_result r_result;
    t_otc_result n_result;

    // Single decode stage never back-pressures.
    assign busy     = 1'b0;
    assign n_in_vld = start && !busy;

    // Input register: capture the window on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_cur   <= i_cur_byte;
            r_next  <= i_next_byte;
            r_after <= i_after_byte;
        end
    end

    otc_decode u_decode (
        .i_cur    (r_cur),
        .i_next   (r_next),
        .i_after  (r_after),
        .o_result (n_result)
    );

    // Result register: advance the decode every valid cycle, strobe for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_strobe     = r_out_vld;
    assign o_token_kind = r_result.kind;
    assign o_consumed   = r_result.consumed;
    assign o_outcome    = r_result.outcome;

    // Every accepted beat yields a strobe, through the input and result registers.
    `OTC_ASSERT_IMPLY(a_beat_to_strobe, i_clk, i_rst_n, start && !busy, ##2 o_strobe, "beat lost in pipeline")
    // A strobe needs a beat in the input register in the cycle before.
    `OTC_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !r_in_vld, !o_strobe, "result without beat")
    // Number start consumes nothing and carries no kind.
    `OTC_ASSERT_IMPLY(a_number_start, i_clk, i_rst_n, o_strobe && o_outcome == OUT_NUMBER, o_consumed == LEN_0 && o_token_kind == K_NONE, "bad number start result")
    // Only the three-byte shifts consume three bytes.
    `OTC_ASSERT_IMPLY(a_three_byte, i_clk, i_rst_n, o_strobe && o_consumed == LEN_3, o_token_kind == K_SHL3 || o_token_kind == K_SHR3, "three bytes on non-shift")

endmodule
